// ----- rtl/png_unf_pkg.sv -----
package png_unf_pkg;

  localparam int MAX_LINE_BYTES  = 8192;
  localparam int MAX_PIXEL_BYTES = 8;

  localparam int LB_W   = 14;                        // line_bytes register width
  localparam int PB_W   = 4;                         // pixel_bytes register width
  localparam int POS_W  = $clog2(MAX_LINE_BYTES);    // line store address
  localparam int HIST_W = $clog2(MAX_PIXEL_BYTES);   // history tap select

  // config register indexes
  localparam logic CFG_LINE_BYTES  = 1'b0;
  localparam logic CFG_PIXEL_BYTES = 1'b1;

  // filter types
  localparam logic [2:0] FILT_NONE  = 3'd0;
  localparam logic [2:0] FILT_SUB   = 3'd1;
  localparam logic [2:0] FILT_UP    = 3'd2;
  localparam logic [2:0] FILT_AVG   = 3'd3;
  localparam logic [2:0] FILT_PAETH = 3'd4;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  typedef struct packed {
    logic             bad;         // error request: no sample
    logic [7:0]       data;
    logic [POS_W-1:0] pos;
    logic [2:0]       kind;
    logic             first_line;  // line above counts as zeros
    logic             last;        // last byte of the line
  } item_t;

  typedef struct packed {
    logic              valid;
    logic              full;
    logic [QPTR_W:0]   count;
  } queue_stat_t;

  function automatic logic [7:0] paeth_pred(input logic [7:0] a, input logic [7:0] b,
                                            input logic [7:0] c);
    logic signed [9:0] p;
    logic signed [9:0] da;
    logic signed [9:0] db;
    logic signed [9:0] dc;
    logic [9:0] pa;
    logic [9:0] pb;
    logic [9:0] pc;
    p  = $signed({2'b00, a}) + $signed({2'b00, b}) - $signed({2'b00, c});
    da = p - $signed({2'b00, a});
    db = p - $signed({2'b00, b});
    dc = p - $signed({2'b00, c});
    pa = da[9] ? 10'(-da) : 10'(da);
    pb = db[9] ? 10'(-db) : 10'(db);
    pc = dc[9] ? 10'(-dc) : 10'(dc);
    if (pa <= pb && pa <= pc) return a;
    else if (pb <= pc) return b;
    else return c;
  endfunction

endpackage

// ----- rtl/png_unf_ifs.sv -----
interface png_unf_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       image_start;
  modport source (output valid, output data_byte, output image_start, input ready);
  modport sink   (input valid, input data_byte, input image_start, output ready);
endinterface

interface png_unf_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] pixel_byte;
  logic       line_end;
  logic       bad_filter;
  modport source (output valid, output pixel_byte, output line_end, output bad_filter,
                  input ready);
  modport sink   (input valid, input pixel_byte, input line_end, input bad_filter,
                  output ready);
endinterface

// ----- rtl/png_unf_ram.sv -----
module png_unf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- rtl/png_unf_queue.sv -----
module png_unf_queue
  import png_unf_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  input  item_t       push_item,
  input  logic        pop,
  output item_t       head,
  output queue_stat_t stat
);

  item_t             slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   count;

  assign head       = slots[rd_ptr];
  assign stat.valid = (count != '0);
  assign stat.full  = (count == (QPTR_W + 1)'(QUEUE_DEPTH));
  assign stat.count = count;

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      count <= count + (QPTR_W + 1)'(push) - (QPTR_W + 1)'(pop);
    end
  end

endmodule

// ----- rtl/png_unf_front.sv -----
module png_unf_front
  import png_unf_pkg::*;
(
  input  logic            clk,
  input  logic            rst,
  png_unf_in_if.sink      in_ch,
  input  logic [LB_W-1:0] line_bytes,   // already clamped to 1..MAX
  input  logic            q_full,
  output logic            push,
  output item_t           push_item
);

  logic [POS_W-1:0] pos, pos_next;
  logic [2:0]       kind, kind_next;
  logic             awaiting, awaiting_next;
  logic             first_line, first_line_next;
  logic             err, err_next;

  logic accept;
  logic last;

  assign in_ch.ready = !q_full;
  assign accept      = in_ch.valid && in_ch.ready;
  assign last        = ({1'b0, pos} + 1'b1) >= line_bytes;

  always_comb begin
    pos_next        = pos;
    kind_next       = kind;
    awaiting_next   = awaiting;
    first_line_next = first_line;
    err_next        = err;
    push            = 1'b0;
    push_item.bad        = 1'b0;
    push_item.data       = in_ch.data_byte;
    push_item.pos        = pos;
    push_item.kind       = kind;
    push_item.first_line = first_line;
    push_item.last       = last;
    if (accept) begin
      if (in_ch.image_start) begin
        err_next        = 1'b0;
        first_line_next = 1'b1;
        awaiting_next   = 1'b1;
      end
      if (!err_next) begin
        if (awaiting_next) begin
          pos_next = '0;
          if (in_ch.data_byte > {5'b0, FILT_PAETH}) begin
            err_next      = 1'b1;
            push          = 1'b1;
            push_item.bad = 1'b1;
          end else begin
            kind_next     = in_ch.data_byte[2:0];
            awaiting_next = 1'b0;
          end
        end else begin
          push = 1'b1;
          if (last) begin
            awaiting_next   = 1'b1;
            first_line_next = 1'b0;
            pos_next        = '0;
          end else begin
            pos_next = pos + 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos        <= '0;
      kind       <= FILT_NONE;
      awaiting   <= 1'b1;
      first_line <= 1'b1;
      err        <= 1'b0;
    end else begin
      pos        <= pos_next;
      kind       <= kind_next;
      awaiting   <= awaiting_next;
      first_line <= first_line_next;
      err        <= err_next;
    end
  end

endmodule

// ----- rtl/png_unf_back.sv -----
module png_unf_back
  import png_unf_pkg::*;
(
  input  logic            clk,
  input  logic            rst,
  input  logic [PB_W-1:0] pixel_bytes,  // already clamped to 1..MAX
  input  item_t           head,
  input  logic            head_valid,
  output logic            pop,
  png_unf_out_if.source   out_ch
);

  item_t            cur;
  logic             cur_valid;
  logic             fwd;
  logic [7:0]       fwd_data;
  logic [7:0]       ram_q;
  logic [7:0]       left_hist [MAX_PIXEL_BYTES];
  logic [7:0]       ul_hist   [MAX_PIXEL_BYTES];

  logic             commit;
  logic             wr;
  logic [HIST_W-1:0] tap;
  logic             has_left;
  logic [7:0]       a, b, c, pred, r;
  logic [8:0]       ab_sum;

  assign commit = cur_valid && (!out_ch.valid || out_ch.ready);
  assign pop    = head_valid && (!cur_valid || commit);
  assign wr     = commit && !cur.bad;

  png_unf_ram #(.WIDTH(8), .DEPTH(MAX_LINE_BYTES)) u_line_store (
    .clk   (clk),
    .we    (wr),
    .waddr (cur.pos),
    .wdata (r),
    .re    (pop),
    .raddr (head.pos),
    .rdata (ram_q)
  );

  assign tap      = HIST_W'(pixel_bytes - 1'b1);
  assign has_left = cur.pos >= POS_W'(pixel_bytes);
  assign a        = has_left ? left_hist[tap] : 8'd0;
  assign c        = has_left ? ul_hist[tap]   : 8'd0;
  // previous write to the same address lands at the edge the read was taken
  assign b        = cur.first_line ? 8'd0 : (fwd ? fwd_data : ram_q);
  assign ab_sum   = {1'b0, a} + {1'b0, b};

  always_comb begin
    case (cur.kind)
      FILT_SUB:   pred = a;
      FILT_UP:    pred = b;
      FILT_AVG:   pred = ab_sum[8:1];
      FILT_PAETH: pred = paeth_pred(a, b, c);
      default:    pred = 8'd0;
    endcase
  end

  assign r = cur.data + pred;

  always_ff @(posedge clk) begin
    if (pop) begin
      cur      <= head;
      fwd      <= wr && (cur.pos == head.pos);
      fwd_data <= r;
    end
    if (wr) begin
      left_hist[0] <= r;
      ul_hist[0]   <= b;
      for (int i = 1; i < MAX_PIXEL_BYTES; i++) begin
        left_hist[i] <= left_hist[i-1];
        ul_hist[i]   <= ul_hist[i-1];
      end
    end
    if (commit) begin
      out_ch.pixel_byte <= cur.bad ? 8'd0 : r;
      out_ch.line_end   <= !cur.bad && cur.last;
      out_ch.bad_filter <= cur.bad;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid    <= 1'b0;
      out_ch.valid <= 1'b0;
    end else begin
      cur_valid    <= pop || (cur_valid && !commit);
      out_ch.valid <= commit || (out_ch.valid && !out_ch.ready);
    end
  end

endmodule

// ----- rtl/png_scanline_unfilter.sv -----
// PNG scanline unfilter (filter method 0). Takes one decompressed byte per request:
// a filter-type byte opens each line, then line_bytes sample bytes follow, each
// rebuilt with None, Sub, Up, Average or Paeth and returned as one pixel_byte, with
// line_end on the last byte of the line. image_start on a byte forces it to be read
// as the filter byte of the first line of an image (line above taken as zeros) and
// clears any error. A filter type above 4 returns a single result with bad_filter
// set, then all bytes are dropped until the next image_start. Filter bytes and
// dropped bytes return nothing. Throughput is one byte per cycle while the output
// is ready, set by the single-port-write line store and the reconstruct stage; a
// sample passes the queue, then the cur register, then the output register. The
// front end keeps only line position, filter and error state, a four-entry queue
// decouples it from the reconstruct side, and output backpressure stalls the front
// only once that queue fills. line_bytes and pixel_bytes are clamped to 1..8192
// and 1..8 and must only be written while the block is idle. There is no clearing
// pass: line store data is used only at positions the previous line wrote.
module png_scanline_unfilter
  import png_unf_pkg::*;
(
  input  logic            clk,
  input  logic            rst,
  input  logic            wr_en,
  input  logic            wr_index,
  input  logic [LB_W-1:0] wr_data,
  png_unf_in_if.sink      in_ch,
  png_unf_out_if.source   out_ch
);

  logic [LB_W-1:0] line_bytes;
  logic [PB_W-1:0] pixel_bytes;
  logic [LB_W-1:0] lb_clamped;
  logic [PB_W-1:0] pb_clamped;

  logic        push;
  item_t       push_item;
  logic        pop;
  item_t       head;
  queue_stat_t q_stat;

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      line_bytes  <= LB_W'(1);
      pixel_bytes <= PB_W'(1);
    end else if (wr_en) begin
      case (wr_index)
        CFG_LINE_BYTES:  line_bytes  <= wr_data;
        CFG_PIXEL_BYTES: pixel_bytes <= wr_data[PB_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    lb_clamped = line_bytes;
    if (line_bytes == '0) lb_clamped = LB_W'(1);
    else if (line_bytes > LB_W'(MAX_LINE_BYTES)) lb_clamped = LB_W'(MAX_LINE_BYTES);
    pb_clamped = pixel_bytes;
    if (pixel_bytes == '0) pb_clamped = PB_W'(1);
    else if (pixel_bytes > PB_W'(MAX_PIXEL_BYTES)) pb_clamped = PB_W'(MAX_PIXEL_BYTES);
  end

  // front: filter byte decode, line position, error/drop state
  png_unf_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_ch     (in_ch),
    .line_bytes(lb_clamped),
    .q_full    (q_stat.full),
    .push      (push),
    .push_item (push_item)
  );

  png_unf_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .head      (head),
    .stat      (q_stat)
  );

  // back: line store read, reconstruct, output register
  png_unf_back u_back (
    .clk        (clk),
    .rst        (rst),
    .pixel_bytes(pb_clamped),
    .head       (head),
    .head_valid (q_stat.valid),
    .pop        (pop),
    .out_ch     (out_ch)
  );

  // an error result never carries sample data or a line end
  a_bad_clean: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && out_ch.bad_filter |-> out_ch.pixel_byte == 8'd0 && !out_ch.line_end)
    else $error("error result carries data");

  // no request taken while the queue has no room
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    q_stat.full |-> !in_ch.ready)
    else $error("request taken with full queue");

  // queue occupancy follows push and pop
  a_queue_count: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) |-> q_stat.count == $past(q_stat.count) + (QPTR_W + 1)'($past(push))
                                    - (QPTR_W + 1)'($past(pop)))
    else $error("queue count mismatch");

endmodule

// ----- test/tb_top.sv -----
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import png_unf_pkg::*;

  // Hang guard. The slowest legal run is every request hit by a full sender gap
  // and a full receiver stall, with some 600 requests, the long holds and the
  // settles on top; this limit is set at ten times that run.
  localparam int CYCLE_LIMIT   = 200_000;
  // Filter bytes and dropped bytes return nothing. Before touching the registers,
  // give the pipeline (two stages plus the 4-entry queue) time to drain.
  localparam int SETTLE_CYCLES = 10;
  // Length of each long output stall that backs the block up to its input.
  localparam int LONG_HOLD     = 300;

  typedef struct packed {
    logic [7:0] pix;
    logic       last;
    logic       bad;
  } px_res_t;

  typedef enum logic {ROW_ITEM, ROW_REGS} row_kind_e;

  // One directed row is either a request or a register update. The typed
  // result is used only where it is obvious; all other rows go to the predictor.
  typedef struct packed {
    row_kind_e   kind;
    logic [7:0]  data;
    logic        start;
    logic        typed;
    px_res_t     want;
    logic [13:0] lb;
    logic [13:0] pb;
  } stim_row_t;

  localparam stim_row_t DIRECTED [27] = '{
    // reset settings: 1 byte per line, 1 byte per pixel, no image start seen yet
    '{ROW_ITEM, 8'h00, 1'b0, 1'b0, '{8'h00, 1'b0, 1'b0}, 14'd0, 14'd0}, // None
    '{ROW_ITEM, 8'hFF, 1'b0, 1'b1, '{8'hFF, 1'b1, 1'b0}, 14'd0, 14'd0},
    '{ROW_ITEM, 8'h02, 1'b0, 1'b0, '{8'h00, 1'b0, 1'b0}, 14'd0, 14'd0}, // Up
    '{ROW_ITEM, 8'h01, 1'b0, 1'b0, '{8'h00, 1'b0, 1'b0}, 14'd0, 14'd0},
    '{ROW_ITEM, 8'h05, 1'b0, 1'b1, '{8'h00, 1'b0, 1'b1}, 14'd0, 14'd0}, // bad type
    '{ROW_ITEM, 8'h33, 1'b0, 1'b0, '{8'h00, 1'b0, 1'b0}, 14'd0, 14'd0}, // dropped
    '{ROW_ITEM, 8'hFF, 1'b1, 1'b1, '{8'h00, 1'b0, 1'b1}, 14'd0, 14'd0}, // start, bad
    '{ROW_REGS, 8'h00, 1'b0, 1'b0, '{8'h00, 1'b0, 1'b0}, 14'd3, 14'd2},
    '{ROW_ITEM, 8'h01, 1'b1, 1'b0, '{8'h00, 1'b0, 1'b0}, 14'd0, 14'd0}, // Sub
    '{ROW_ITEM, 8'h80, 1'b0, 1'b0, '{8'h00, 1'b0, 1'b0}, 14'd0, 14'd0},
    '{ROW_ITEM, 8'h7F, 1'b0, 1'b0, '{8'h00, 1'b0, 1'b0}, 14'd0, 14'd0},
    '{ROW_ITEM, 8'h01, 1'b0, 1'b0, '{8'h00, 1'b0, 1'b0}, 14'd0, 14'd0},
    '{ROW_ITEM, 8'h04, 1'b0, 1'b0, '{8'h00, 1'b0, 1'b0}, 14'd0, 14'd0}, // Paeth
    '{ROW_ITEM, 8'h00, 1'b0, 1'b0, '{8'h00, 1'b0, 1'b0}, 14'd0, 14'd0},
    '{ROW_ITEM, 8'hFF, 1'b0, 1'b0, '{8'h00, 1'b0, 1'b0}, 14'd0, 14'd0},
    '{ROW_ITEM, 8'h10, 1'b0, 1'b0, '{8'h00, 1'b0, 1'b0}, 14'd0, 14'd0},
    '{ROW_ITEM, 8'h02, 1'b0, 1'b0, '{8'h00, 1'b0, 1'b0}, 14'd0, 14'd0}, // Up
    '{ROW_ITEM, 8'h10, 1'b0, 1'b0, '{8'h00, 1'b0, 1'b0}, 14'd0, 14'd0},
    '{ROW_ITEM, 8'h03, 1'b1, 1'b0, '{8'h00, 1'b0, 1'b0}, 14'd0, 14'd0}, // start mid-line
    '{ROW_ITEM, 8'hFF, 1'b0, 1'b0, '{8'h00, 1'b0, 1'b0}, 14'd0, 14'd0},
    '{ROW_ITEM, 8'h00, 1'b0, 1'b0, '{8'h00, 1'b0, 1'b0}, 14'd0, 14'd0},
    '{ROW_ITEM, 8'h55, 1'b0, 1'b0, '{8'h00, 1'b0, 1'b0}, 14'd0, 14'd0},
    '{ROW_REGS, 8'h00, 1'b0, 1'b0, '{8'h00, 1'b0, 1'b0}, 14'd0, 14'd0}, // both clamp up
    '{ROW_ITEM, 8'h04, 1'b1, 1'b0, '{8'h00, 1'b0, 1'b0}, 14'd0, 14'd0},
    '{ROW_ITEM, 8'h00, 1'b0, 1'b1, '{8'h00, 1'b1, 1'b0}, 14'd0, 14'd0},
    '{ROW_ITEM, 8'h00, 1'b0, 1'b0, '{8'h00, 1'b0, 1'b0}, 14'd0, 14'd0},
    '{ROW_ITEM, 8'hFF, 1'b0, 1'b1, '{8'hFF, 1'b1, 1'b0}, 14'd0, 14'd0}
  };

  logic            clk = 1'b0;
  logic            rst;
  logic            wr_en;
  logic            wr_index;
  logic [LB_W-1:0] wr_data;

  png_unf_in_if  in_ch ();
  png_unf_out_if out_ch ();

  png_scanline_unfilter i_dut (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data),
    .in_ch    (in_ch),
    .out_ch   (out_ch)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Unfilter predictor: the expected state of the block, updated per accepted request
  // ---------------------------------------------------------------------------
  logic [13:0] cfg_line = 14'd1;
  logic [3:0]  cfg_pix  = 4'd1;
  logic [7:0]  row_above    [MAX_LINE_BYTES];
  logic [7:0]  left_hist    [MAX_PIXEL_BYTES] = '{default: 8'h00};
  logic [7:0]  up_left_hist [MAX_PIXEL_BYTES] = '{default: 8'h00};
  int          position    = 0;
  logic [2:0]  kind        = FILT_NONE;
  bit          want_filter = 1'b1;
  bit          top_row     = 1'b1;  // line above reads as zeros
  bit          stuck       = 1'b0;  // bad filter seen, drop until image start

  px_res_t expected_px [$];
  int      live_items  = 0;  // accepted requests that were not dropped
  int      mismatches  = 0;
  int      cycles      = 0;

  // Knobs that the stimulus and the output sink share.
  bit      idle_on           = 1'b1;
  int      idle_odds         = 5;
  bit      long_hold_pending = 1'b0;

  function automatic int clamp_line(input logic [13:0] v);
    if (v == 14'd0) return 1;
    if (v > MAX_LINE_BYTES) return MAX_LINE_BYTES;
    return int'(v);
  endfunction

  function automatic int paeth_pick(input int a, input int b, input int c);
    int p, da, db, dc;
    p  = a + b - c;
    da = (p > a) ? p - a : a - p;
    db = (p > b) ? p - b : b - p;
    dc = (p > c) ? p - c : c - p;
    if (da <= db && da <= dc) return a;
    if (db <= dc) return b;
    return c;
  endfunction

  task automatic predict_px(input logic [7:0] x, input logic s, output bit got,
                            output px_res_t r, output bit dropped);
    int lb, pb, pos, a, b, c, sum;
    got     = 1'b0;
    dropped = 1'b0;
    r       = '0;
    lb = clamp_line(cfg_line);
    pb = (cfg_pix == 4'd0) ? 1 : (cfg_pix > MAX_PIXEL_BYTES) ? MAX_PIXEL_BYTES : int'(cfg_pix);
    // image start forces a filter byte, clears the error, zeros the line above
    if (s) begin
      stuck       = 1'b0;
      top_row     = 1'b1;
      want_filter = 1'b1;
    end
    if (stuck) begin
      dropped = 1'b1;
      return;
    end
    if (want_filter) begin
      left_hist    = '{default: 8'h00};
      up_left_hist = '{default: 8'h00};
      position     = 0;
      if (x > 8'(FILT_PAETH)) begin
        stuck = 1'b1;
        r.bad = 1'b1;
        got   = 1'b1;
        return;
      end
      kind        = x[2:0];
      want_filter = 1'b0;
      return;
    end
    pos = position;
    b   = top_row ? 0 : int'(row_above[pos]);
    // left edge: a and c read as zero within the first pixel
    a   = (pos >= pb) ? int'(left_hist[pb-1]) : 0;
    c   = (pos >= pb) ? int'(up_left_hist[pb-1]) : 0;
    case (kind)
      FILT_SUB:   sum = x + a;
      FILT_UP:    sum = x + b;
      FILT_AVG:   sum = x + ((a + b) >> 1);
      FILT_PAETH: sum = x + paeth_pick(a, b, c);
      default:    sum = x;
    endcase
    r.pix          = 8'(sum);
    row_above[pos] = r.pix;
    for (int i = MAX_PIXEL_BYTES - 1; i > 0; i--) begin
      left_hist[i]    = left_hist[i-1];
      up_left_hist[i] = up_left_hist[i-1];
    end
    left_hist[0]    = r.pix;
    up_left_hist[0] = 8'(b);
    got = 1'b1;
    if (pos + 1 >= lb) begin
      r.last      = 1'b1;
      want_filter = 1'b1;
      top_row     = 1'b0;
      position    = 0;
    end else begin
      position = pos + 1;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Input side
  // ---------------------------------------------------------------------------

  // Offers one request and waits for it to be taken. The predictor runs on the
  // edge that takes it. Its results must first pass the queue, the cur register and
  // the output register, so the result check on that same edge never needs them.
  task automatic send_byte(input logic [7:0] x, input logic s, input bit typed,
                           input px_res_t typed_res);
    bit      got, dropped;
    px_res_t r;
    if (idle_on && $urandom_range(0, idle_odds) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.data_byte   <= x;
    in_ch.image_start <= s;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    predict_px(x, s, got, r, dropped);
    if (got) expected_px.insert(expected_px.size(), typed ? typed_res : r);
    if (!dropped) live_items++;
  endtask

  // Drop valid, let every expected result come out, then wait out the tail of
  // any trailing filter or dropped bytes.
  task automatic settle();
    in_ch.valid <= 1'b0;
    while (expected_px.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Writes both registers on back-to-back edges, line_bytes first. wr_en stays high
  // across both writes.
  task automatic write_regs(input logic [13:0] lb_raw, input logic [13:0] pb_raw);
    wr_en    <= 1'b1;
    wr_index <= CFG_LINE_BYTES;
    wr_data  <= lb_raw;
    @(posedge clk);
    wr_index <= CFG_PIXEL_BYTES;
    wr_data  <= pb_raw;
    @(posedge clk);
    wr_en    <= 1'b0;
    cfg_line = lb_raw;
    cfg_pix  = pb_raw[3:0];
  endtask

  function automatic logic [13:0] pick_line();
    case ($urandom_range(0, 9))
      0:       return 14'd0;
      1:       return 14'($urandom_range(13, 40));
      default: return 14'($urandom_range(1, 10));
    endcase
  endfunction

  // Upper data bits are don't-care for pixel_bytes, so fill them with noise.
  function automatic logic [13:0] pick_pix();
    logic [13:0] v;
    v = 14'($urandom);
    case ($urandom_range(0, 11))
      0:       v[3:0] = 4'd0;
      1:       v[3:0] = 4'hF;
      2:       v[3:0] = 4'($urandom_range(9, 14));
      default: v[3:0] = 4'($urandom_range(1, MAX_PIXEL_BYTES));
    endcase
    return v;
  endfunction

  function automatic logic [7:0] pick_byte();
    if ($urandom_range(0, 7) == 0) return $urandom_range(0, 1) ? 8'hFF : 8'h00;
    return 8'($urandom);
  endfunction

  // One setting of the registers. Each phase opens with image start, so a longer
  // line never reads store entries that were never written. Most lines are
  // complete lines of random filter type. The rest are bad filter types followed
  // by junk, and lines cut short by an image start.
  task automatic run_phase(input logic [13:0] lb_raw, input logic [13:0] pb_raw,
                           input int budget, input bit noisy, input bit squeeze);
    int lb_eff, mark, k, roll;
    bit need_start;
    settle();
    write_regs(lb_raw, pb_raw);
    if (squeeze) long_hold_pending = 1'b1;
    lb_eff     = clamp_line(lb_raw);
    need_start = 1'b1;
    mark       = live_items;
    while (live_items - mark < budget) begin
      roll = noisy ? $urandom_range(0, 99) : 99;
      if (roll < 8) begin
        send_byte(8'($urandom_range(5, 255)), need_start | 1'($urandom_range(0, 1)),
                  1'b0, '0);
        repeat ($urandom_range(0, 4)) send_byte(8'($urandom), 1'b0, 1'b0, '0);
        need_start = 1'b1;
      end else begin
        k = (roll < 16) ? $urandom_range(0, lb_eff - 1) : lb_eff;
        send_byte(8'($urandom_range(FILT_NONE, FILT_PAETH)),
                  need_start | (noisy && $urandom_range(0, 9) == 0), 1'b0, '0);
        need_start = (k < lb_eff);
        repeat (k) send_byte(pick_byte(), 1'b0, 1'b0, '0);
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Output side: random stalls in short bursts. When asked, one long hold-off
  // fills the internal queue and backs up the input.
  // ---------------------------------------------------------------------------
  initial begin
    int stall_left;
    stall_left = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (long_hold_pending) begin
        long_hold_pending = 1'b0;
        stall_left        = LONG_HOLD;
      end else if (stall_left == 0 && idle_on && $urandom_range(0, idle_odds) == 0) begin
        stall_left = $urandom_range(1, 15);
      end
      if (stall_left > 0) begin
        out_ch.ready <= 1'b0;
        stall_left--;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // Compare every accepted result with the oldest expected one.
  always @(posedge clk) begin
    px_res_t want;
    if (!rst && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      if (expected_px.size() == 0) begin
        $error("unexpected result: pixel_byte %02h line_end %0b bad_filter %0b",
               out_ch.pixel_byte, out_ch.line_end, out_ch.bad_filter);
        mismatches++;
      end else begin
        want = expected_px.pop_front();
        if (out_ch.pixel_byte !== want.pix) begin
          $error("pixel_byte: expected %02h, got %02h", want.pix, out_ch.pixel_byte);
          mismatches++;
        end
        if (out_ch.line_end !== want.last) begin
          $error("line_end: expected %0b, got %0b", want.last, out_ch.line_end);
          mismatches++;
        end
        if (out_ch.bad_filter !== want.bad) begin
          $error("bad_filter: expected %0b, got %0b", want.bad, out_ch.bad_filter);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("tb_top: done, errors");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    int phase, small_items, mark;
    rst               <= 1'b1;
    wr_en             <= 1'b0;
    wr_index          <= CFG_LINE_BYTES;
    wr_data           <= '0;
    in_ch.valid       <= 1'b0;
    in_ch.data_byte   <= '0;
    in_ch.image_start <= 1'b0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // directed rows: reset settings, every filter type, errors, clamping
    foreach (DIRECTED[i]) begin
      if (DIRECTED[i].kind == ROW_REGS) begin
        settle();
        write_regs(DIRECTED[i].lb, DIRECTED[i].pb);
      end else begin
        send_byte(DIRECTED[i].data, DIRECTED[i].start, DIRECTED[i].typed, DIRECTED[i].want);
      end
    end

    // Random phases. Two of them use the largest line setting (the exact maximum,
    // then a value that clamps to it) and send only the head of one line, so no
    // early line end may show up. The next phase opens with image start.
    phase       = 0;
    small_items = 0;
    while (phase < 8 || small_items < 280) begin
      if (phase == 2 || phase == 5) begin
        settle();
        write_regs((phase == 2) ? 14'd8192 : 14'h3FFF, pick_pix());
        send_byte(8'($urandom_range(FILT_NONE, FILT_PAETH)), 1'b1, 1'b0, '0);
        repeat (20) send_byte(pick_byte(), 1'b0, 1'b0, '0);
      end else begin
        mark = live_items;
        run_phase(pick_line(), pick_pix(), $urandom_range(20, 60), 1'b1,
                  phase == 1 || phase == 4);
        small_items += live_items - mark;
      end
      phase++;
    end

    // last stretch at full rate on both sides
    idle_on = 1'b0;
    repeat (2) run_phase(pick_line(), pick_pix(), $urandom_range(20, 30), 1'b1, 1'b0);

    settle();
    if (mismatches == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule

// ----- png_scanline_unfilter.f -----
rtl/png_unf_pkg.sv
rtl/png_unf_ifs.sv
rtl/png_unf_ram.sv
rtl/png_unf_queue.sv
rtl/png_unf_front.sv
rtl/png_unf_back.sv
rtl/png_scanline_unfilter.sv
test/tb_top.sv
